/* src/sorted_key_table_top_assert.svh */
// ----------------------------------------------------------------------------
// sorted_key_table_top_assert.svh
// Assertion macros for the sorted key table. Clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SKT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Shared widths, codes and control types of the sorted key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

    localparam int DEPTH_DEFAULT = 32;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int ENTRY_W  = KEY_W + HANDLE_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

    // result kinds loaded into the output register
    localparam logic [2:0] RES_NOP     = 3'd0;
    localparam logic [2:0] RES_FULL    = 3'd1;
    localparam logic [2:0] RES_RANGE   = 3'd2;
    localparam logic [2:0] RES_MISSING = 3'd3;
    localparam logic [2:0] RES_INS     = 3'd4;
    localparam logic [2:0] RES_DEL     = 3'd5;
    localparam logic [2:0] RES_FIND    = 3'd6;

    // table write source
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_NEW   = 2'd1;
    localparam logic [1:0] WR_CARRY = 2'd2;
    localparam logic [1:0] WR_SHIFT = 2'd3;

    typedef struct packed {
        logic       load_req;
        logic       prime;
        logic       step;
        logic [1:0] wr_sel;
        logic       load_carry;
        logic       capture;
        logic       load_out;
        logic [2:0] res;
    } skt_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            pos_bad;
        logic            at_count;
        logic            next_at_count;
        logic            key_ge;
        logic            key_eq;
        logic            out_busy;
    } skt_stat_t;

endpackage

/* src/skt_if.sv */
// ----------------------------------------------------------------------------
// skt_if
// Request and response channels of the sorted key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface skt_req_if;
    logic                         valid;
    logic                         ready;
    logic [skt_pkg::OP_W-1:0]     op;
    logic [skt_pkg::KEY_W-1:0]    key;
    logic [skt_pkg::HANDLE_W-1:0] record_handle;
    logic [skt_pkg::POS_W-1:0]    position;

    modport source (output valid, output op, output key, output record_handle,
                    output position, input ready);
    modport sink   (input valid, input op, input key, input record_handle,
                    input position, output ready);
endinterface

interface skt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [skt_pkg::STATUS_W-1:0] status;
    logic [skt_pkg::POS_W-1:0]    found_position;
    logic [skt_pkg::HANDLE_W-1:0] found_handle;
    logic [skt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output found_position,
                    output found_handle, output entry_count, input ready);
    modport sink   (input valid, input status, input found_position,
                    input found_handle, input entry_count, output ready);
endinterface

/* src/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer of the sorted key table: decodes the op and steps the table scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  skt_pkg::skt_stat_t st,
    output skt_pkg::skt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PRIME    = 3'd1;
    localparam logic [2:0] S_INS_SEEK = 3'd2;
    localparam logic [2:0] S_INS_SHFT = 3'd3;
    localparam logic [2:0] S_DEL      = 3'd4;
    localparam logic [2:0] S_FIND     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] res_reg;
    logic [2:0] res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= skt_pkg::RES_NOP;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        res_next   = res_reg;
        req_ready  = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_PRIME;
                end
            end
            S_PRIME:
            begin
                unique case (st.op)
                    skt_pkg::OP_INSERT:
                    begin
                        if (st.full)
                        begin
                            res_next   = skt_pkg::RES_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.prime  = 1'b1;
                            state_next = S_INS_SEEK;
                        end
                    end
                    skt_pkg::OP_DELETE:
                    begin
                        if (st.pos_bad)
                        begin
                            res_next   = skt_pkg::RES_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.prime  = 1'b1;
                            state_next = S_DEL;
                        end
                    end
                    skt_pkg::OP_FIND:
                    begin
                        if (st.empty)
                        begin
                            res_next   = skt_pkg::RES_MISSING;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.prime  = 1'b1;
                            state_next = S_FIND;
                        end
                    end
                    default:
                    begin
                        res_next   = skt_pkg::RES_NOP;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS_SEEK:
            begin
                // first slot whose key is not smaller, or the end of the table
                if (st.at_count || st.key_ge)
                begin
                    cmd.wr_sel     = skt_pkg::WR_NEW;
                    cmd.load_carry = 1'b1;
                    cmd.capture    = 1'b1;
                    if (st.at_count)
                    begin
                        res_next   = skt_pkg::RES_INS;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = S_INS_SHFT;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_INS_SHFT:
            begin
                cmd.wr_sel     = skt_pkg::WR_CARRY;
                cmd.load_carry = 1'b1;
                if (st.at_count)
                begin
                    res_next   = skt_pkg::RES_INS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_DEL:
            begin
                if (!st.at_count)
                begin
                    cmd.wr_sel = skt_pkg::WR_SHIFT;
                    cmd.step   = 1'b1;
                end
                else
                begin
                    res_next   = skt_pkg::RES_DEL;
                    state_next = S_DONE;
                end
            end
            S_FIND:
            begin
                if (st.key_eq)
                begin
                    cmd.capture = 1'b1;
                    res_next    = skt_pkg::RES_FIND;
                    state_next  = S_DONE;
                end
                else if (st.next_at_count)
                begin
                    res_next   = skt_pkg::RES_MISSING;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.res      = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/skt_datapath.sv */
// ----------------------------------------------------------------------------
// skt_datapath
// Table memory, scan pointer, carry register, entry count and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_datapath
#(
    parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [skt_pkg::OP_W-1:0]       req_op,
    input  logic [skt_pkg::KEY_W-1:0]      req_key,
    input  logic [skt_pkg::HANDLE_W-1:0]   req_handle,
    input  logic [skt_pkg::POS_W-1:0]      req_position,
    input  skt_pkg::skt_cmd_t              cmd,
    output skt_pkg::skt_stat_t             st,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [skt_pkg::STATUS_W-1:0]   rsp_status,
    output logic [skt_pkg::POS_W-1:0]      rsp_found_position,
    output logic [skt_pkg::HANDLE_W-1:0]   rsp_found_handle,
    output logic [skt_pkg::COUNT_W-1:0]    rsp_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > skt_pkg::COUNT_W) ? CW : skt_pkg::COUNT_W;
    localparam int EW = skt_pkg::ENTRY_W;
    localparam int HW = skt_pkg::HANDLE_W;

    logic [EW-1:0] mem [DEPTH];

    logic [skt_pkg::OP_W-1:0]  op_reg;
    logic [skt_pkg::KEY_W-1:0] key_reg;
    logic [HW-1:0]             hnd_reg;
    logic [skt_pkg::POS_W-1:0] pos_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             w_reg;
    logic [CW-1:0]             w_next;
    logic [EW-1:0]             rd_data_reg;
    logic [EW-1:0]             carry_reg;
    logic [CW-1:0]             slot_reg;
    logic [HW-1:0]             fhnd_reg;
    logic                      out_valid_reg;
    logic [skt_pkg::STATUS_W-1:0] out_status_reg;
    logic [skt_pkg::POS_W-1:0] out_pos_reg;
    logic [HW-1:0]             out_hnd_reg;
    logic [skt_pkg::COUNT_W-1:0] out_cnt_reg;

    logic [XW-1:0] pos_ext;
    logic [XW-1:0] cnt_ext;
    logic [XW-1:0] del_start;
    logic [XW-1:0] slot_ext;
    logic [XW-1:0] cnt_new_ext;
    logic [CW-1:0] w_plus1;
    logic [CW-1:0] w_minus1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_en;
    logic [skt_pkg::STATUS_W-1:0] res_status;
    logic [skt_pkg::POS_W-1:0]    res_pos;
    logic [HW-1:0]                res_hnd;

    assign pos_ext     = XW'(pos_reg);
    assign cnt_ext     = XW'(count_reg);
    assign del_start   = pos_ext + XW'(1);
    assign slot_ext    = XW'(slot_reg);
    assign w_plus1     = w_reg + CW'(1);
    assign w_minus1    = w_reg - CW'(1);
    assign cnt_new_ext = XW'(count_next);

    assign st.op            = op_reg;
    assign st.full          = (count_reg == CW'(DEPTH));
    assign st.empty         = (count_reg == '0);
    assign st.pos_bad       = (pos_ext >= cnt_ext);
    assign st.at_count      = (w_reg == count_reg);
    assign st.next_at_count = (w_plus1 == count_reg);
    assign st.key_ge        = (rd_data_reg[EW-1:HW] >= key_reg);
    assign st.key_eq        = (rd_data_reg[EW-1:HW] == key_reg);
    assign st.out_busy      = out_valid_reg && !rsp_ready;

    // a delete scan starts one past the removed entry, the others at zero
    always_comb
    begin
        if (cmd.prime)
        begin
            w_next  = (op_reg == skt_pkg::OP_DELETE) ? del_start[CW-1:0] : '0;
            rd_addr = (op_reg == skt_pkg::OP_DELETE) ? del_start[AW-1:0] : '0;
        end
        else
        begin
            w_next  = cmd.step ? w_plus1 : w_reg;
            rd_addr = w_plus1[AW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = w_reg[AW-1:0];
        wr_data = carry_reg;
        unique case (cmd.wr_sel)
            skt_pkg::WR_NEW:   wr_data = {key_reg, hnd_reg};
            skt_pkg::WR_CARRY: wr_data = carry_reg;
            skt_pkg::WR_SHIFT:
            begin
                wr_addr = w_minus1[AW-1:0];
                wr_data = rd_data_reg;
            end
            default:           wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= req_op;
            key_reg <= req_key;
            hnd_reg <= req_handle;
            pos_reg <= req_position;
        end
        w_reg <= w_next;
        if (cmd.load_carry)
        begin
            carry_reg <= rd_data_reg;
        end
        if (cmd.capture)
        begin
            slot_reg <= w_reg;
            fhnd_reg <= rd_data_reg[HW-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        res_status = skt_pkg::ST_OK;
        res_pos    = '0;
        res_hnd    = '0;
        case (cmd.res)
            skt_pkg::RES_FULL:    res_status = skt_pkg::ST_FULL;
            skt_pkg::RES_RANGE:   res_status = skt_pkg::ST_RANGE;
            skt_pkg::RES_MISSING: res_status = skt_pkg::ST_MISSING;
            skt_pkg::RES_INS:
            begin
                res_pos    = slot_ext[skt_pkg::POS_W-1:0];
                count_next = count_reg + CW'(1);
            end
            skt_pkg::RES_DEL:
            begin
                res_pos    = pos_reg;
                count_next = count_reg - CW'(1);
            end
            skt_pkg::RES_FIND:
            begin
                res_pos = slot_ext[skt_pkg::POS_W-1:0];
                res_hnd = fhnd_reg;
            end
            default:              res_status = skt_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status;
            out_pos_reg    <= res_pos;
            out_hnd_reg    <= res_hnd;
            out_cnt_reg    <= cnt_new_ext[skt_pkg::COUNT_W-1:0];
        end
    end

    assign rsp_valid          = out_valid_reg;
    assign rsp_status         = out_status_reg;
    assign rsp_found_position = out_pos_reg;
    assign rsp_found_handle   = out_hnd_reg;
    assign rsp_entry_count    = out_cnt_reg;

endmodule

/* src/sorted_key_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Insert, find and delete scan the table RAM one entry per cycle; a NOP and a
// rejected request (table full, position out of range, find on empty) do not scan.
// One transaction at a time; the next request is taken once the result is in
// the output register. Reset clears the count and all control, not the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_key_table_top_assert.svh"

module sorted_key_table_top
#(
    parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    skt_req_if.sink   req,
    skt_rsp_if.source rsp
);

    skt_pkg::skt_cmd_t  cmd;
    skt_pkg::skt_stat_t st;

    skt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    skt_datapath #(.DEPTH(DEPTH)) u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_op             (req.op),
        .req_key            (req.key),
        .req_handle         (req.record_handle),
        .req_position       (req.position),
        .cmd                (cmd),
        .st                 (st),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .rsp_status         (rsp.status),
        .rsp_found_position (rsp.found_position),
        .rsp_found_handle   (rsp.found_handle),
        .rsp_entry_count    (rsp.entry_count)
    );

    `SKT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
    `SKT_ASSERT_IMPLY(a_full_status, rsp.valid && rsp.status == skt_pkg::ST_FULL, st.full, "full status without full table")
    `SKT_ASSERT_IMPLY(a_load_needs_room, cmd.load_out, !st.out_busy, "result loaded over pending transaction")

endmodule
